/* hw/rtl/fbw_pkg.sv */
// fbw_pkg: shared types and constants for the flow-driven bilinear warp block.
// Holds queue word layout, command kinds, register indexes and reset values.
// No dependencies.
`timescale 1ns / 1ps

package fbw_pkg;

  localparam int DEF_MAX_COLS   = 256;
  localparam int DEF_MAX_ROWS   = 256;
  localparam int DEF_PIXEL_BITS = 16;

  localparam int QUEUE_DEPTH = 4;

  localparam int COORD_W = 12;   // covers the largest store dimension
  localparam int SIZE_W  = 13;   // holds a clamped image size
  localparam int CFG_W   = 16;
  localparam int FLOW_W  = 16;
  localparam int PIX_W   = 16;   // pixel field width at the ports
  localparam int FRAC_W  = 8;

  localparam logic [8:0]  RST_ACTIVE_COLS = 9'd256;
  localparam logic [8:0]  RST_ACTIVE_ROWS = 9'd256;
  localparam logic [15:0] RST_FLOW_SCALE  = 16'd4096;

  typedef enum logic [1:0] {
    REG_ACTIVE_COLS = 2'd0,
    REG_ACTIVE_ROWS = 2'd1,
    REG_FLOW_SCALE  = 2'd2
  } reg_index_t;

  typedef enum logic [0:0] {
    OP_LOAD = 1'b0,
    OP_WARP = 1'b1
  } op_code_t;

  typedef enum logic [2:0] {
    CMD_SKIP,    // load outside the store
    CMD_LOAD,    // write one source pixel
    CMD_BLEND,   // target inside, bilinear blend
    CMD_COPY,    // target outside, return own pixel
    CMD_ZERO     // own position outside the store
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t            kind;
    logic [COORD_W-1:0]   row;
    logic [COORD_W-1:0]   col;
    logic [FRAC_W-1:0]    fx;
    logic [FRAC_W-1:0]    fy;
    logic [PIX_W-1:0]     pixel;
  } queue_word_t;

endpackage

/* hw/rtl/fbw_ram.sv */
// fbw_ram: generic single-write, single-read RAM with registered read data.
// Depends on nothing.
`timescale 1ns / 1ps

module fbw_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* hw/rtl/fbw_front.sv */
// fbw_front: accepts words, scales the flow, computes the target and classifies
// each word into a queue word. Depends on fbw_pkg.
`timescale 1ns / 1ps

module fbw_front import fbw_pkg::*; #(
  parameter int MAX_COLS = DEF_MAX_COLS,
  parameter int MAX_ROWS = DEF_MAX_ROWS,
  parameter int QDEPTH   = QUEUE_DEPTH
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  output logic                        busy,
  input  logic                        op,
  input  logic [7:0]                  row,
  input  logic [7:0]                  col,
  input  logic [PIX_W-1:0]            pixel,
  input  logic signed [FLOW_W-1:0]    flow_x,
  input  logic signed [FLOW_W-1:0]    flow_y,
  input  logic [8:0]                  active_cols,
  input  logic [8:0]                  active_rows,
  input  logic [CFG_W-1:0]            flow_scale,
  input  logic [$clog2(QDEPTH+1)-1:0] q_count,
  output logic                        push,
  output queue_word_t                 push_word
);

  localparam int QCNT_W = $clog2(QDEPTH + 1);
  localparam logic [SIZE_W-1:0] MAXC = SIZE_W'(MAX_COLS);
  localparam logic [SIZE_W-1:0] MAXR = SIZE_W'(MAX_ROWS);

  logic                     s1_v;
  logic                     s1_op;
  logic [7:0]               s1_row, s1_col;
  logic [PIX_W-1:0]         s1_pixel;
  logic signed [FLOW_W-1:0] s1_fx, s1_fy;

  logic                     s2_v;
  logic                     s2_op;
  logic [7:0]               s2_row, s2_col;
  logic [PIX_W-1:0]         s2_pixel;
  logic signed [32:0]       s2_px, s2_py;

  logic [QCNT_W:0]          pending;
  logic signed [22:0]       tx, ty;
  logic [SIZE_W-1:0]        cols_c, rows_c, ac_ext, ar_ext;
  logic [20:0]              lim_x, lim_y;
  logic                     in_tgt, store_ok;

  assign pending = {1'b0, q_count} + (QCNT_W+1)'(s1_v) + (QCNT_W+1)'(s2_v);
  assign busy    = pending >= (QCNT_W+1)'(QDEPTH);

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v <= 1'b0;
      s2_v <= 1'b0;
    end else begin
      s1_v <= start && !busy;
      s2_v <= s1_v;
    end
    s1_op    <= op;
    s1_row   <= row;
    s1_col   <= col;
    s1_pixel <= pixel;
    s1_fx    <= flow_x;
    s1_fy    <= flow_y;
    s2_op    <= s1_op;
    s2_row   <= s1_row;
    s2_col   <= s1_col;
    s2_pixel <= s1_pixel;
    s2_px    <= s1_fx * $signed({1'b0, flow_scale});
    s2_py    <= s1_fy * $signed({1'b0, flow_scale});
  end

  // floor(p / 4096) is an arithmetic shift by 12
  assign tx = $signed({7'd0, s2_col, 8'd0}) + $signed({{2{s2_px[32]}}, s2_px[32:12]});
  assign ty = $signed({7'd0, s2_row, 8'd0}) + $signed({{2{s2_py[32]}}, s2_py[32:12]});

  assign ac_ext = {4'd0, active_cols};
  assign ar_ext = {4'd0, active_rows};
  assign cols_c = (ac_ext < SIZE_W'(2)) ? SIZE_W'(2) : ((ac_ext > MAXC) ? MAXC : ac_ext);
  assign rows_c = (ar_ext < SIZE_W'(2)) ? SIZE_W'(2) : ((ar_ext > MAXR) ? MAXR : ar_ext);
  assign lim_x  = {cols_c - SIZE_W'(1), 8'd0};
  assign lim_y  = {rows_c - SIZE_W'(1), 8'd0};

  assign in_tgt = !tx[22] && !ty[22] &&
                  (tx[21:0] < {1'b0, lim_x}) && (ty[21:0] < {1'b0, lim_y});
  assign store_ok = ({5'd0, s2_row} < MAXR) && ({5'd0, s2_col} < MAXC);

  always_comb begin
    push_word.pixel = s2_pixel;
    push_word.row   = {4'd0, s2_row};
    push_word.col   = {4'd0, s2_col};
    push_word.fx    = '0;
    push_word.fy    = '0;
    if (s2_op == OP_LOAD) begin
      push_word.kind = store_ok ? CMD_LOAD : CMD_SKIP;
    end else if (!store_ok) begin
      push_word.kind = CMD_ZERO;
    end else if (in_tgt) begin
      push_word.kind = CMD_BLEND;
      push_word.row  = ty[8 +: COORD_W];
      push_word.col  = tx[8 +: COORD_W];
      push_word.fx   = tx[7:0];
      push_word.fy   = ty[7:0];
    end else begin
      push_word.kind = CMD_COPY;
    end
  end

  assign push = s2_v;

endmodule

/* hw/rtl/fbw_queue.sv */
// fbw_queue: short FIFO of queue words between the front and back ends.
// Depends on fbw_pkg.
`timescale 1ns / 1ps

module fbw_queue import fbw_pkg::*; #(
  parameter int DEPTH = QUEUE_DEPTH
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       push,
  input  queue_word_t                push_word,
  input  logic                       pop,
  output logic                       not_empty,
  output queue_word_t                head,
  output logic [$clog2(DEPTH+1)-1:0] count
);

  localparam int PTR_W = (DEPTH > 2) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  queue_word_t      slots [DEPTH];
  logic [PTR_W-1:0] wptr, rptr;

  assign not_empty = count != '0;
  assign head      = slots[rptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wptr <= (wptr == PTR_W'(DEPTH - 1)) ? '0 : wptr + PTR_W'(1);
      end
      if (pop) begin
        rptr <= (rptr == PTR_W'(DEPTH - 1)) ? '0 : rptr + PTR_W'(1);
      end
      count <= count + CNT_W'(push) - CNT_W'(pop);
    end
    if (push) begin
      slots[wptr] <= push_word;
    end
  end

endmodule

/* hw/rtl/fbw_back.sv */
// fbw_back: reads the four-bank image store, weights the neighbors and sums
// them into a result word. Depends on fbw_pkg and fbw_ram.
`timescale 1ns / 1ps

module fbw_back import fbw_pkg::*; #(
  parameter int MAX_COLS   = DEF_MAX_COLS,
  parameter int MAX_ROWS   = DEF_MAX_ROWS,
  parameter int PIXEL_BITS = DEF_PIXEL_BITS
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              q_valid,
  input  queue_word_t       head,
  output logic              pop,
  output logic              done,
  output logic [PIX_W-1:0]  warped_value,
  output logic              in_bounds
);

  localparam int ROW_W = (MAX_ROWS > 4) ? $clog2(MAX_ROWS) : 2;
  localparam int COL_W = (MAX_COLS > 4) ? $clog2(MAX_COLS) : 2;
  localparam int BA_W  = (ROW_W - 1) + (COL_W - 1);
  localparam int PROD_W = PIXEL_BITS + 17;
  localparam int SUM_W  = (PIXEL_BITS + 19 > 32) ? PIXEL_BITS + 19 : 32;

  logic [ROW_W-1:0]           y, y1;
  logic [COL_W-1:0]           x, x1;
  logic [8:0]                 gx, gy;
  logic [PIXEL_BITS+15:0]     pix_ext;
  logic                       weighted;

  logic [16:0]                w_next [4];
  logic [PIXEL_BITS-1:0]      ram_q  [4];

  logic                       b1_v, b2_v;
  cmd_kind_t                  b1_kind, b2_kind;
  logic [16:0]                b1_w   [4];
  logic [3:0]                 b1_use;
  logic [PROD_W-1:0]          b2_prod [4];
  logic [SUM_W-1:0]           total;

  assign pop      = q_valid;
  assign y        = head.row[ROW_W-1:0];
  assign x        = head.col[COL_W-1:0];
  assign y1       = y + ROW_W'(1);
  assign x1       = x + COL_W'(1);
  assign gx       = 9'd256 - {1'b0, head.fx};
  assign gy       = 9'd256 - {1'b0, head.fy};
  assign pix_ext  = {{PIXEL_BITS{1'b0}}, head.pixel};
  assign weighted = head.kind inside {CMD_BLEND, CMD_COPY};

  // bank {rp,cp} holds pixels whose row parity is rp and column parity is cp
  for (genvar b = 0; b < 4; b++) begin : g_bank
    localparam logic RP = 1'(b >> 1);
    localparam logic CP = 1'(b & 1);

    logic [ROW_W-1:0] rb;
    logic [COL_W-1:0] cb;
    logic [BA_W-1:0]  addr;
    logic [8:0]       wy, wx;
    logic [17:0]      wprod;
    logic             we;

    assign rb    = (y[0] == RP) ? y : y1;
    assign cb    = (x[0] == CP) ? x : x1;
    assign addr  = {rb[ROW_W-1:1], cb[COL_W-1:1]};
    assign wy    = (y[0] == RP) ? gy : {1'b0, head.fy};
    assign wx    = (x[0] == CP) ? gx : {1'b0, head.fx};
    assign wprod = wx * wy;
    assign w_next[b] = weighted ? wprod[16:0] : '0;
    assign we    = pop && (head.kind == CMD_LOAD) && (y[0] == RP) && (x[0] == CP);

    fbw_ram #(
      .WIDTH (PIXEL_BITS),
      .DEPTH (2 ** BA_W)
    ) u_ram (
      .clk   (clk),
      .we    (we),
      .waddr (addr),
      .wdata (pix_ext[PIXEL_BITS-1:0]),
      .raddr (addr),
      .rdata (ram_q[b])
    );
  end

  assign total = SUM_W'(b2_prod[0]) + SUM_W'(b2_prod[1]) +
                 SUM_W'(b2_prod[2]) + SUM_W'(b2_prod[3]);

  always_ff @(posedge clk) begin
    if (rst) begin
      b1_v <= 1'b0;
      b2_v <= 1'b0;
      done <= 1'b0;
    end else begin
      b1_v <= pop;
      b2_v <= b1_v;
      done <= b2_v && (b2_kind inside {CMD_BLEND, CMD_COPY, CMD_ZERO});
    end
    b1_kind <= head.kind;
    b2_kind <= b1_kind;
    for (int i = 0; i < 4; i++) begin
      b1_w[i]    <= w_next[i];
      b1_use[i]  <= w_next[i] != '0;
      b2_prod[i] <= b1_use[i] ? PROD_W'(b1_w[i]) * PROD_W'(ram_q[i]) : '0;
    end
    warped_value <= total[16 +: PIX_W];
    in_bounds    <= b2_kind == CMD_BLEND;
  end

endmodule

/* hw/rtl/flow_bilinear_warp.sv */
// flow_bilinear_warp: top level, configuration registers, front end, queue, back end.
// Depends on fbw_pkg, fbw_front, fbw_queue, fbw_back.
`timescale 1ns / 1ps

// One word is taken per clock when start is high and busy is low. A load word
// (op 0) writes one pixel into the store and gives no result; a warp word
// (op 1) gives exactly one result, marked by done for a single clock, in
// order. The back end drains the queue one word every clock, so busy stays
// low in normal use and results never wait; the receiver must take each
// result in the cycle done is high. The store is four parity banks read in
// parallel, so all four neighbors come in one access. The user must write
// registers through cfg_write only while no warp is in flight; the block does
// not enforce this; store entries must be loaded before a warp reads them.
module flow_bilinear_warp import fbw_pkg::*; #(
  parameter int MAX_COLS   = DEF_MAX_COLS,
  parameter int MAX_ROWS   = DEF_MAX_ROWS,
  parameter int PIXEL_BITS = DEF_PIXEL_BITS
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  output logic                     busy,
  input  logic                     op,
  input  logic [7:0]               row,
  input  logic [7:0]               col,
  input  logic [PIX_W-1:0]         pixel,
  input  logic signed [FLOW_W-1:0] flow_x,
  input  logic signed [FLOW_W-1:0] flow_y,
  output logic                     done,
  output logic [PIX_W-1:0]         warped_value,
  output logic                     in_bounds,
  input  logic                     cfg_write,
  input  logic [1:0]               cfg_index,
  input  logic [CFG_W-1:0]         cfg_data
);

  localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

  logic [8:0]        active_cols, active_rows;
  logic [CFG_W-1:0]  flow_scale;
  logic              push, q_valid, pop;
  queue_word_t       push_word, head;
  logic [QCNT_W-1:0] q_count;

  always_ff @(posedge clk) begin
    if (rst) begin
      active_cols <= RST_ACTIVE_COLS;
      active_rows <= RST_ACTIVE_ROWS;
      flow_scale  <= RST_FLOW_SCALE;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_ACTIVE_COLS: active_cols <= cfg_data[8:0];
        REG_ACTIVE_ROWS: active_rows <= cfg_data[8:0];
        REG_FLOW_SCALE:  flow_scale  <= cfg_data;
        default: ;
      endcase
    end
  end

  fbw_front #(
    .MAX_COLS (MAX_COLS),
    .MAX_ROWS (MAX_ROWS),
    .QDEPTH   (QUEUE_DEPTH)
  ) u_front (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .busy        (busy),
    .op          (op),
    .row         (row),
    .col         (col),
    .pixel       (pixel),
    .flow_x      (flow_x),
    .flow_y      (flow_y),
    .active_cols (active_cols),
    .active_rows (active_rows),
    .flow_scale  (flow_scale),
    .q_count     (q_count),
    .push        (push),
    .push_word   (push_word)
  );

  fbw_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_word (push_word),
    .pop       (pop),
    .not_empty (q_valid),
    .head      (head),
    .count     (q_count)
  );

  fbw_back #(
    .MAX_COLS   (MAX_COLS),
    .MAX_ROWS   (MAX_ROWS),
    .PIXEL_BITS (PIXEL_BITS)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .q_valid      (q_valid),
    .head         (head),
    .pop          (pop),
    .done         (done),
    .warped_value (warped_value),
    .in_bounds    (in_bounds)
  );

endmodule

/* hw/rtl/fbw_checker.sv */
// fbw_checker: port-level checks on word timing of flow_bilinear_warp, bound to the top.
// Depends on fbw_pkg and flow_bilinear_warp.
`timescale 1ns / 1ps

module fbw_checker import fbw_pkg::*; (
  input logic clk,
  input logic rst,
  input logic start,
  input logic busy,
  input logic op,
  input logic done
);

  localparam int LAT = 6;

  // every warp word gives a result
  a_warp_done: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && op == OP_WARP) |-> ##LAT done)
    else $error("warp word without result");

  // a load word gives no result
  a_load_quiet: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && op == OP_LOAD) |-> ##LAT !done)
    else $error("result from load word");

  // no result without a warp taken earlier
  a_done_src: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy && !rst && op == OP_WARP, LAT))
    else $error("result without warp word");

  a_reset_quiet: assert property (@(posedge clk)
    (!rst && $past(rst)) |-> !done)
    else $error("result right after reset");

endmodule

bind flow_bilinear_warp fbw_checker u_fbw_checker (
  .clk   (clk),
  .rst   (rst),
  .start (start),
  .busy  (busy),
  .op    (op),
  .done  (done)
);
